// ----- design/uiss_pkg.sv -----
// ----------------------------------------------------------------------------
// uiss_pkg
// Shared widths, status codes and controller/datapath handshake structs for
// the used-index skip set.
// ----------------------------------------------------------------------------
package uiss_pkg;

   localparam int INDEX_W         = 64;
   localparam int LIMIT_W         = 7;
   localparam int COUNT_OUT_W     = 7;
   localparam int STATUS_W        = 2;
   localparam int DEF_MAX_SKIPPED = 64;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } uiss_status_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_run;
      logic decide;
      logic ins_run;
      logic out_load;
   } uiss_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic need_insert;
      logic ins_done;
      logic out_free;
   } uiss_stat_type;

endpackage

// ----- design/uiss_req_if.sv -----
// ----------------------------------------------------------------------------
// uiss_req_if
// Request channel: command and index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uiss_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [uiss_pkg::INDEX_W-1:0]  index_value;

   modport source (output valid, output command, output index_value, input ready);
   modport sink   (input valid, input command, input index_value, output ready);
endinterface

// ----- design/uiss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// uiss_rsp_if
// Response channel: status, skipped hit flag and table fill, valid/ready.
// ----------------------------------------------------------------------------
interface uiss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [uiss_pkg::STATUS_W-1:0]     status;
   logic                              was_skipped;
   logic [uiss_pkg::COUNT_OUT_W-1:0]  skipped_count;

   modport source (output valid, output status, output was_skipped,
                   output skipped_count, input ready);
   modport sink   (input valid, input status, input was_skipped,
                   input skipped_count, output ready);
endinterface

// ----- design/uiss_csr_if.sv -----
// ----------------------------------------------------------------------------
// uiss_csr_if
// Configuration write channel carrying the skip limit register.
// ----------------------------------------------------------------------------
interface uiss_csr_if;
   logic                          valid;
   logic                          ready;
   logic [uiss_pkg::LIMIT_W-1:0]  skip_limit;

   modport source (output valid, output skip_limit, input ready);
   modport sink   (input valid, input skip_limit, output ready);
endinterface

// ----- design/used_index_skip_set_unit.sv -----
// ----------------------------------------------------------------------------
// used_index_skip_set_unit
// Used-index tracker with a high-water mark and a bounded skipped-index table.
//
// req_bus carries one transaction per item: command (0 check, 1 add) and a
// 64-bit index. rsp_bus returns one transaction per item: status (accepted,
// duplicate, capacity exceeded), was_skipped and the table fill afterwards.
// csr_bus writes skip_limit; it is always ready. The user must write it while
// idle; the block does not enforce this. One item is in work at a time.
// From acceptance it passes through the table scan, which reads one RAM entry
// per cycle, and the decision to the result register; when an add opens a
// gap, an insertion pass follows the decision: the insertion pointer walks the
// slots one per cycle and fills each free one with the next gap index.
// The next request can be taken in the cycle after the result is loaded.
// Reset clears the mark, the fill count and every entry's valid bit at once
// and sets skip_limit to 64; no clearing pass is needed. A stalled response
// holds in the output register while the next item is accepted and worked;
// that item waits for the register to free before its result is loaded.
// ----------------------------------------------------------------------------
module used_index_skip_set_unit #(
   parameter int MAX_SKIPPED = uiss_pkg::DEF_MAX_SKIPPED
) (
   input  logic         clock,
   input  logic         reset,
   uiss_req_if.sink     req_bus,
   uiss_rsp_if.source   rsp_bus,
   uiss_csr_if.sink     csr_bus
);

   uiss_pkg::uiss_cmd_type  cmd;
   uiss_pkg::uiss_stat_type stat;
   logic                    csr_we;

   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid;

   uiss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uiss_dpath #(
      .MAX_SKIPPED (MAX_SKIPPED)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_data        (csr_bus.skip_limit),
      .req_command     (req_bus.command),
      .req_index       (req_bus.index_value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_was_skipped (rsp_bus.was_skipped),
      .rsp_count       (rsp_bus.skipped_count)
   );

   // one item in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while an item is in work");

   // a loaded result shows up on the response channel
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_bus.valid)
      else $error("loaded result not presented");

   // hit flag only goes with an accepted status
   a_was_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.was_skipped) |-> (rsp_bus.status == uiss_pkg::ST_OK))
      else $error("skipped hit reported with a failing status");

   // insertion never runs past the end of its gap
   a_ins_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_run |-> !stat.ins_done)
      else $error("insert step issued after the gap was filled");

endmodule

// ----- design/uiss_ram.sv -----
// ----------------------------------------------------------------------------
// uiss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uiss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/uiss_ctrl.sv -----
// ----------------------------------------------------------------------------
// uiss_ctrl
// Sequencer: accept, table scan, decision, gap insertion, result hand-off.
// ----------------------------------------------------------------------------
module uiss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  uiss_pkg::uiss_stat_type stat,
   output uiss_pkg::uiss_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DECIDE,
      INSERT,
      FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (stat.scan_done) begin
               state_in = DECIDE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.need_insert ? INSERT : FINISH;
         end
         INSERT: begin
            if (stat.ins_done) begin
               state_in = FINISH;
            end else begin
               cmd.ins_run = 1'b1;
            end
         end
         FINISH: begin
            cmd.out_load = stat.out_free;
            if (stat.out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/uiss_dpath.sv -----
// ----------------------------------------------------------------------------
// uiss_dpath
// Datapath: high-water mark, skipped-index table with valid bits, scan
// compare, capacity check, gap insertion and the output register.
// ----------------------------------------------------------------------------
module uiss_dpath #(
   parameter int MAX_SKIPPED = uiss_pkg::DEF_MAX_SKIPPED
) (
   input  logic                                clock,
   input  logic                                reset,
   input  uiss_pkg::uiss_cmd_type              cmd,
   output uiss_pkg::uiss_stat_type             stat,
   input  logic                                csr_we,
   input  logic [uiss_pkg::LIMIT_W-1:0]        csr_data,
   input  logic                                req_command,
   input  logic [uiss_pkg::INDEX_W-1:0]        req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [uiss_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_was_skipped,
   output logic [uiss_pkg::COUNT_OUT_W-1:0]    rsp_count
);

   localparam int IW     = uiss_pkg::INDEX_W;
   localparam int IDX_W  = (MAX_SKIPPED > 1) ? $clog2(MAX_SKIPPED) : 1;
   localparam int PTR_W  = $clog2(MAX_SKIPPED + 1);
   localparam int CNT_W  = $clog2(MAX_SKIPPED + 1);
   localparam int LW     = (CNT_W > uiss_pkg::LIMIT_W) ? CNT_W : uiss_pkg::LIMIT_W;
   localparam logic [PTR_W-1:0] PTR_END = PTR_W'(MAX_SKIPPED);
   localparam logic [LW-1:0]    MAX_LW  = LW'(MAX_SKIPPED);

   logic [uiss_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [IW-1:0]                mark_ff, mark_in;
   logic [MAX_SKIPPED-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   logic                         add_ff, add_in;
   logic [IW-1:0]                v_ff, v_in;
   logic [PTR_W-1:0]             ptr_ff, ptr_in;
   logic                         pend_ff, pend_in;
   logic                         vld_q_ff, vld_q_in;
   logic [IDX_W-1:0]             addr_q_ff, addr_q_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             slot_ff, slot_in;
   logic                         below_ff, below_in;
   logic [IW-1:0]                gap_ff, gap_in;
   logic [IW-1:0]                k_ff, k_in;
   logic [LW-1:0]                remain_ff, remain_in;
   uiss_pkg::uiss_status_type    res_status_ff, res_status_in;
   logic                         res_was_ff, res_was_in;

   logic                         out_valid_ff, out_valid_in;
   logic [uiss_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;
   logic                         out_was_ff, out_was_in;
   logic [uiss_pkg::COUNT_OUT_W-1:0] out_count_ff, out_count_in;

   logic [IDX_W-1:0]             idx;
   logic                         ram_we;
   logic                         ram_re;
   logic [IW-1:0]                ram_rdata;
   logic [LW-1:0]                limit_act;
   logic [LW-1:0]                cnt_ext;
   logic [LW-1:0]                room;
   logic                         full;
   logic [IW-1:0]                next_mark;

   assign idx       = ptr_ff[IDX_W-1:0];
   assign cnt_ext   = LW'(count_ff);
   assign limit_act = (LW'(limit_ff) < MAX_LW) ? LW'(limit_ff) : MAX_LW;
   assign room      = limit_act - cnt_ext;
   assign full      = (cnt_ext > limit_act) || (gap_ff > IW'(room));
   // the all-ones index pins the mark instead of wrapping
   assign next_mark = (v_ff == '1) ? v_ff : v_ff + IW'(1);

   assign ram_re = cmd.scan_run && (ptr_ff != PTR_END);
   assign ram_we = cmd.ins_run && !valid_ff[idx];

   uiss_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_SKIPPED)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data (k_ff),
      .rd_en   (ram_re),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      limit_in      = limit_ff;
      mark_in       = mark_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      add_in        = add_ff;
      v_in          = v_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      vld_q_in      = vld_q_ff;
      addr_q_in     = addr_q_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      below_in      = below_ff;
      gap_in        = gap_ff;
      k_in          = k_ff;
      remain_in     = remain_ff;
      res_status_in = res_status_ff;
      res_was_in    = res_was_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_was_in    = out_was_ff;
      out_count_in  = out_count_ff;

      if (csr_we) begin
         limit_in = csr_data;
      end

      if (cmd.load_req) begin
         add_in   = req_command;
         v_in     = req_index;
         ptr_in   = '0;
         found_in = 1'b0;
      end

      // read issue stage
      if (ram_re) begin
         pend_in   = 1'b1;
         vld_q_in  = valid_ff[idx];
         addr_q_in = idx;
         ptr_in    = ptr_ff + PTR_W'(1);
      end
      if (cmd.scan_run) begin
         below_in = v_ff < mark_ff;
         gap_in   = v_ff - mark_ff;
      end
      // compare stage, in the cycle after the read issue
      if (pend_ff && vld_q_ff && (ram_rdata == v_ff)) begin
         found_in = 1'b1;
         slot_in  = addr_q_ff;
      end

      if (cmd.decide) begin
         res_was_in    = 1'b0;
         res_status_in = uiss_pkg::ST_OK;
         ptr_in        = '0;
         k_in          = mark_ff;
         remain_in     = LW'(gap_ff);
         if (found_ff) begin
            res_was_in = 1'b1;
            if (add_ff) begin
               valid_in[slot_ff] = 1'b0;
               count_in          = count_ff - CNT_W'(1);
            end
         end else if (below_ff) begin
            res_status_in = uiss_pkg::ST_DUP;
         end else if (full) begin
            res_status_in = uiss_pkg::ST_FULL;
         end else if (add_ff && (gap_ff == '0)) begin
            mark_in = next_mark;
         end
      end

      if (cmd.ins_run) begin
         ptr_in = ptr_ff + PTR_W'(1);
         if (!valid_ff[idx]) begin
            valid_in[idx] = 1'b1;
            count_in      = count_ff + CNT_W'(1);
            k_in          = k_ff + IW'(1);
            remain_in     = remain_ff - LW'(1);
            if (remain_ff == LW'(1)) begin
               mark_in = next_mark;
            end
         end
      end

      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_was_in    = res_was_ff;
         out_count_in  = uiss_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   always_comb begin
      stat.scan_done   = (ptr_ff == PTR_END) && !pend_ff;
      stat.need_insert = !found_ff && !below_ff && !full && add_ff && (gap_ff != '0);
      stat.ins_done    = (remain_ff == '0);
      stat.out_free    = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= uiss_pkg::LIMIT_RESET;
         mark_ff      <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         mark_ff      <= mark_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      add_ff        <= add_in;
      v_ff          <= v_in;
      ptr_ff        <= ptr_in;
      vld_q_ff      <= vld_q_in;
      addr_q_ff     <= addr_q_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      below_ff      <= below_in;
      gap_ff        <= gap_in;
      k_ff          <= k_in;
      remain_ff     <= remain_in;
      res_status_ff <= res_status_in;
      res_was_ff    <= res_was_in;
      out_status_ff <= out_status_in;
      out_was_ff    <= out_was_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_was_skipped = out_was_ff;
   assign rsp_count       = out_count_ff;

endmodule
